// ===== rtl/core/pinhole_primary_ray_direction_top_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the primary ray direction block
// Shared concurrent assertion forms, clocked on i_clk, with and without a reset disable.
// ---------------------------------------------------------------------------
`ifndef PINHOLE_PRIMARY_RAY_DIRECTION_TOP_DEFINES_SVH
`define PINHOLE_PRIMARY_RAY_DIRECTION_TOP_DEFINES_SVH

// checked only out of reset
`define RPD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge
`define RPD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/core/rpd_pkg.sv =====
// ---------------------------------------------------------------------------
// rpd_pkg
// Types and constants shared by the primary ray direction pipeline.
// ---------------------------------------------------------------------------
`default_nettype none
package rpd_pkg;

    localparam int DIR_FRAC_BITS_DEF = 14;
    localparam int POS_W   = 16;
    localparam int COMP_W  = 16;
    localparam int NRM_W   = 20;
    localparam int MAG_W   = 35;
    localparam int NMAG_W  = 31;
    localparam int SUM_W   = 64;
    localparam int LEN_W   = 32;
    localparam int OUT_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 60;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASIS_U       = 3'd0,
        CFG_BASIS_V       = 3'd1,
        CFG_SCALED_NORMAL = 3'd2,
        CFG_HALF_WIDTH    = 3'd3,
        CFG_HALF_HEIGHT   = 3'd4
    } t_cfg_idx;

    // per-item data that rides alongside the square root
    typedef struct packed {
        logic [2:0][NMAG_W-1:0] mag;
        logic [2:0]             neg;
        logic                   degen;
    } t_side;

endpackage
`default_nettype wire

// ===== rtl/core/rpd_dir.sv =====
// ---------------------------------------------------------------------------
// rpd_dir
// Recentre the sample and form the raw direction x*u + y*v - n, 3 stages.
// ---------------------------------------------------------------------------
`default_nettype none
module rpd_dir (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_en,
    input  wire logic                                  i_valid,
    input  wire logic [rpd_pkg::POS_W-1:0]             i_plane_x,
    input  wire logic [rpd_pkg::POS_W-1:0]             i_plane_y,
    input  wire logic [3*rpd_pkg::COMP_W-1:0]          i_basis_u,
    input  wire logic [3*rpd_pkg::COMP_W-1:0]          i_basis_v,
    input  wire logic [3*rpd_pkg::NRM_W-1:0]           i_scaled_normal,
    input  wire logic [rpd_pkg::POS_W-1:0]             i_half_width,
    input  wire logic [rpd_pkg::POS_W-1:0]             i_half_height,
    output logic                                       o_valid,
    output logic [2:0][rpd_pkg::MAG_W-1:0]             o_mag,
    output logic [2:0]                                 o_neg
);

    logic [2:0]          r_vld;
    logic signed [16:0]  r_xc;
    logic signed [16:0]  r_yc;
    logic signed [32:0]  r_pu [3];
    logic signed [32:0]  r_pv [3];
    logic signed [29:0]  r_nc [3];
    logic [2:0][rpd_pkg::MAG_W-1:0] r_mag;
    logic [2:0]          r_neg;
    logic signed [rpd_pkg::MAG_W-1:0] n_d [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xc <= $signed({1'b0, i_plane_x}) - $signed({1'b0, i_half_width});
            r_yc <= $signed({1'b0, i_plane_y}) - $signed({1'b0, i_half_height});
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_d[i] = rpd_pkg::MAG_W'(r_pu[i]) + rpd_pkg::MAG_W'(r_pv[i])
                   - rpd_pkg::MAG_W'(r_nc[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_pu[i] <= r_xc * $signed(i_basis_u[16*i +: 16]);
                r_pv[i] <= r_yc * $signed(i_basis_v[16*i +: 16]);
                r_nc[i] <= {$signed(i_scaled_normal[20*i +: 20]), 10'd0};
                r_neg[i] <= n_d[i][rpd_pkg::MAG_W-1];
                r_mag[i] <= n_d[i][rpd_pkg::MAG_W-1] ? rpd_pkg::MAG_W'(-n_d[i])
                                                     : rpd_pkg::MAG_W'(n_d[i]);
            end
        end
    end

    assign o_valid = r_vld[2];
    assign o_mag   = r_mag;
    assign o_neg   = r_neg;

endmodule
`default_nettype wire

// ===== rtl/core/rpd_norm.sv =====
// ---------------------------------------------------------------------------
// rpd_norm
// Scale magnitudes so the largest lies in [2^30, 2^31), then sum squares.
// ---------------------------------------------------------------------------
`default_nettype none
module rpd_norm (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_en,
    input  wire logic                                  i_valid,
    input  wire logic [2:0][rpd_pkg::MAG_W-1:0]        i_mag,
    input  wire logic [2:0]                            i_neg,
    output logic                                       o_valid,
    output logic [rpd_pkg::SUM_W-1:0]                  o_sum,
    output rpd_pkg::t_side                             o_side
);

    logic [4:0]                      r_vld;
    logic [rpd_pkg::MAG_W-1:0]       r_m;
    logic [2:0][rpd_pkg::MAG_W-1:0]  r_mag_a;
    logic [2:0][rpd_pkg::MAG_W-1:0]  r_mag_b;
    logic [2:0]                      r_neg_a, r_neg_b;
    logic [5:0]                      r_bl;
    logic [5:0]                      n_bl;
    logic [rpd_pkg::MAG_W-1:0]       n_m;
    rpd_pkg::t_side                  r_side_c, r_side_d, r_side_e;
    rpd_pkg::t_side                  n_side_c;
    logic [61:0]                     r_sq [3];
    logic [rpd_pkg::SUM_W-1:0]       r_sum;
    logic [rpd_pkg::MAG_W-1:0]       n_sh;

    always_comb begin
        n_m = i_mag[0];
        if (i_mag[1] > n_m) n_m = i_mag[1];
        if (i_mag[2] > n_m) n_m = i_mag[2];
    end

    always_comb begin
        n_bl = '0;
        for (int i = 0; i < rpd_pkg::MAG_W; i++) begin
            if (r_m[i]) n_bl = 6'(i + 1);
        end
    end

    always_comb begin
        n_side_c.neg   = r_neg_b;
        n_side_c.degen = (r_bl == 6'd0);
        n_sh = '0;
        for (int i = 0; i < 3; i++) begin
            if (r_bl > 6'd31) n_sh = r_mag_b[i] >> (r_bl - 6'd31);
            else              n_sh = r_mag_b[i] << (6'd31 - r_bl);
            n_side_c.mag[i] = n_sh[rpd_pkg::NMAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m      <= n_m;
            r_mag_a  <= i_mag;
            r_neg_a  <= i_neg;
            r_bl     <= n_bl;
            r_mag_b  <= r_mag_a;
            r_neg_b  <= r_neg_a;
            r_side_c <= n_side_c;
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= 62'(r_side_c.mag[i]) * 62'(r_side_c.mag[i]);
            end
            r_side_d <= r_side_c;
            r_sum    <= 64'(r_sq[0]) + 64'(r_sq[1]) + 64'(r_sq[2]);
            r_side_e <= r_side_d;
        end
    end

    assign o_valid = r_vld[4];
    assign o_sum   = r_sum;
    assign o_side  = r_side_e;

endmodule
`default_nettype wire

// ===== rtl/core/rpd_isqrt.sv =====
// ---------------------------------------------------------------------------
// rpd_isqrt
// Integer square root of a 64-bit sum, one result bit per stage.
// ---------------------------------------------------------------------------
`default_nettype none
module rpd_isqrt (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_en,
    input  wire logic                                  i_valid,
    input  wire logic [rpd_pkg::SUM_W-1:0]             i_sum,
    input  wire rpd_pkg::t_side                        i_side,
    output logic                                       o_valid,
    output logic [rpd_pkg::LEN_W-1:0]                  o_len,
    output rpd_pkg::t_side                             o_side
);

    localparam int NS = rpd_pkg::LEN_W;

    logic [NS-1:0]              r_vld;
    logic [rpd_pkg::SUM_W-1:0]  r_num  [NS];
    logic [rpd_pkg::SUM_W-1:0]  r_res  [NS];
    rpd_pkg::t_side             r_side [NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    for (genvar s = 0; s < NS; s++) begin : g_stage
        localparam logic [rpd_pkg::SUM_W-1:0] BIT = 64'd1 << (2 * (NS - 1 - s));
        logic [rpd_pkg::SUM_W-1:0] w_num, w_res, w_try;
        rpd_pkg::t_side            w_side;

        if (s == 0) begin : g_first
            assign w_num  = i_sum;
            assign w_res  = '0;
            assign w_side = i_side;
        end else begin : g_next
            assign w_num  = r_num[s-1];
            assign w_res  = r_res[s-1];
            assign w_side = r_side[s-1];
        end

        assign w_try = w_res + BIT;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[s] <= w_side;
                if (w_num >= w_try) begin
                    r_num[s] <= w_num - w_try;
                    r_res[s] <= (w_res >> 1) + BIT;
                end else begin
                    r_num[s] <= w_num;
                    r_res[s] <= w_res >> 1;
                end
            end
        end
    end

    assign o_valid = r_vld[NS-1];
    assign o_len   = r_res[NS-1][rpd_pkg::LEN_W-1:0];
    assign o_side  = r_side[NS-1];

endmodule
`default_nettype wire

// ===== rtl/core/rpd_div.sv =====
// ---------------------------------------------------------------------------
// rpd_div
// Rounded division of each magnitude by the length, one quotient bit per
// stage, then sign and saturation into the output register.
// ---------------------------------------------------------------------------
`default_nettype none
module rpd_div #(
    parameter int DIR_FRAC_BITS = rpd_pkg::DIR_FRAC_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_en,
    input  wire logic                                  i_valid,
    input  wire logic [rpd_pkg::LEN_W-1:0]             i_len,
    input  wire rpd_pkg::t_side                        i_side,
    output logic                                       o_valid,
    output logic [2:0][rpd_pkg::OUT_W-1:0]             o_dir,
    output logic                                       o_degen
);

    localparam int NW = rpd_pkg::LEN_W + DIR_FRAC_BITS;
    localparam int QW = DIR_FRAC_BITS + 1;

    logic [QW+1:0]               r_vld;
    logic [2:0][NW-1:0]          r_rem0;
    logic [rpd_pkg::LEN_W-1:0]   r_d0;
    logic [2:0]                  r_neg0;
    logic                        r_dg0;
    logic [2:0][NW-1:0]          r_rem [QW];
    logic [2:0][QW-1:0]          r_q   [QW];
    logic [rpd_pkg::LEN_W-1:0]   r_d   [QW];
    logic [2:0]                  r_neg [QW];
    logic                        r_dg  [QW];
    logic [2:0][rpd_pkg::OUT_W-1:0] r_dir;
    logic                        r_degen;
    logic [2:0][rpd_pkg::OUT_W-1:0] n_dir;
    logic [31:0]                 n_q32;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[QW:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_rem0[i] <= (NW'(i_side.mag[i]) << DIR_FRAC_BITS) + NW'(i_len >> 1);
            end
            r_d0   <= i_side.degen ? rpd_pkg::LEN_W'(1) : i_len;
            r_neg0 <= i_side.neg;
            r_dg0  <= i_side.degen;
        end
    end

    for (genvar t = 0; t < QW; t++) begin : g_stage
        localparam int SH = DIR_FRAC_BITS - t;
        logic [2:0][NW-1:0]        w_rem;
        logic [2:0][QW-1:0]        w_q;
        logic [rpd_pkg::LEN_W-1:0] w_d;
        logic [2:0]                w_neg;
        logic                      w_dg;
        logic [NW-1:0]             w_dsh;

        if (t == 0) begin : g_first
            assign w_rem = r_rem0;
            assign w_q   = '0;
            assign w_d   = r_d0;
            assign w_neg = r_neg0;
            assign w_dg  = r_dg0;
        end else begin : g_next
            assign w_rem = r_rem[t-1];
            assign w_q   = r_q[t-1];
            assign w_d   = r_d[t-1];
            assign w_neg = r_neg[t-1];
            assign w_dg  = r_dg[t-1];
        end

        assign w_dsh = NW'(w_d) << SH;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_d[t]   <= w_d;
                r_neg[t] <= w_neg;
                r_dg[t]  <= w_dg;
                for (int i = 0; i < 3; i++) begin
                    if (w_rem[i] >= w_dsh) begin
                        r_rem[t][i] <= w_rem[i] - w_dsh;
                        r_q[t][i]   <= QW'({w_q[i], 1'b1});
                    end else begin
                        r_rem[t][i] <= w_rem[i];
                        r_q[t][i]   <= QW'({w_q[i], 1'b0});
                    end
                end
            end
        end
    end

    always_comb begin
        n_q32 = '0;
        for (int i = 0; i < 3; i++) begin
            n_q32 = 32'(r_q[QW-1][i]);
            if (r_dg[QW-1]) begin
                n_dir[i] = '0;
            end else if (r_neg[QW-1][i]) begin
                n_dir[i] = (n_q32 > 32'd32768) ? 16'h8000 : 16'(-n_q32);
            end else begin
                n_dir[i] = (n_q32 > 32'd32767) ? 16'h7fff : 16'(n_q32);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dir   <= n_dir;
            r_degen <= r_dg[QW-1];
        end
    end

    assign o_valid = r_vld[QW+1];
    assign o_dir   = r_dir;
    assign o_degen = r_degen;

endmodule
`default_nettype wire

// ===== rtl/core/pinhole_primary_ray_direction_top.sv =====
// ---------------------------------------------------------------------------
// pinhole_primary_ray_direction_top
// Pinhole camera primary ray direction: sample position in, unit ray out.
// ---------------------------------------------------------------------------
// One sample enters per clock while the pipeline is not stalled: 3 stages
// form the raw direction, 5 scale it and sum the squares, 32 stages of the
// square root give one length bit each, and the divider takes
// DIR_FRAC_BITS + 3 stages including the output register. A stall on the
// result holds the whole pipeline, and o_stall follows it in the same cycle.
// Configuration writes are always ready.
`default_nettype none
module pinhole_primary_ray_direction_top #(
    parameter int DIR_FRAC_BITS = rpd_pkg::DIR_FRAC_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic [rpd_pkg::POS_W-1:0]             i_plane_x,
    input  wire logic [rpd_pkg::POS_W-1:0]             i_plane_y,
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic signed [rpd_pkg::OUT_W-1:0]           o_dir_x,
    output logic signed [rpd_pkg::OUT_W-1:0]           o_dir_y,
    output logic signed [rpd_pkg::OUT_W-1:0]           o_dir_z,
    output logic                                       o_degenerate,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [rpd_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [rpd_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    logic [47:0] r_basis_u;
    logic [47:0] r_basis_v;
    logic [59:0] r_scaled_normal;
    logic [15:0] r_half_width;
    logic [15:0] r_half_height;

    logic                                  en;
    logic                                  dir_vld, norm_vld, sq_vld, div_vld;
    logic [2:0][rpd_pkg::MAG_W-1:0]        dir_mag;
    logic [2:0]                            dir_neg;
    logic [rpd_pkg::SUM_W-1:0]             norm_sum;
    rpd_pkg::t_side                        norm_side, sq_side;
    logic [rpd_pkg::LEN_W-1:0]             sq_len;
    logic [2:0][rpd_pkg::OUT_W-1:0]        div_dir;
    logic                                  div_degen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_basis_u       <= '0;
            r_basis_v       <= '0;
            r_scaled_normal <= '0;
            r_half_width    <= '0;
            r_half_height   <= '0;
        end else if (i_cfg_valid) begin
            unique case (rpd_pkg::t_cfg_idx'(i_cfg_index))
                rpd_pkg::CFG_BASIS_U:       r_basis_u       <= i_cfg_data[47:0];
                rpd_pkg::CFG_BASIS_V:       r_basis_v       <= i_cfg_data[47:0];
                rpd_pkg::CFG_SCALED_NORMAL: r_scaled_normal <= i_cfg_data;
                rpd_pkg::CFG_HALF_WIDTH:    r_half_width    <= i_cfg_data[15:0];
                rpd_pkg::CFG_HALF_HEIGHT:   r_half_height   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign en          = !(div_vld && i_stall);
    assign o_stall     = div_vld && i_stall;

    rpd_dir u_dir (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (en),
        .i_valid         (i_valid),
        .i_plane_x       (i_plane_x),
        .i_plane_y       (i_plane_y),
        .i_basis_u       (r_basis_u),
        .i_basis_v       (r_basis_v),
        .i_scaled_normal (r_scaled_normal),
        .i_half_width    (r_half_width),
        .i_half_height   (r_half_height),
        .o_valid         (dir_vld),
        .o_mag           (dir_mag),
        .o_neg           (dir_neg)
    );

    rpd_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (dir_vld),
        .i_mag   (dir_mag),
        .i_neg   (dir_neg),
        .o_valid (norm_vld),
        .o_sum   (norm_sum),
        .o_side  (norm_side)
    );

    rpd_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (norm_vld),
        .i_sum   (norm_sum),
        .i_side  (norm_side),
        .o_valid (sq_vld),
        .o_len   (sq_len),
        .o_side  (sq_side)
    );

    rpd_div #(
        .DIR_FRAC_BITS (DIR_FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_vld),
        .i_len   (sq_len),
        .i_side  (sq_side),
        .o_valid (div_vld),
        .o_dir   (div_dir),
        .o_degen (div_degen)
    );

    assign o_valid      = div_vld;
    assign o_dir_x      = $signed(div_dir[0]);
    assign o_dir_y      = $signed(div_dir[1]);
    assign o_dir_z      = $signed(div_dir[2]);
    assign o_degenerate = div_degen;

endmodule
`default_nettype wire

// ===== rtl/core/rpd_checker.sv =====
// ---------------------------------------------------------------------------
// rpd_checker
// Port-level checks on the primary ray direction block, bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none
`include "pinhole_primary_ray_direction_top_defines.svh"
module rpd_checker (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  o_stall,
    input  wire logic                                  o_valid,
    input  wire logic                                  i_stall,
    input  wire logic signed [rpd_pkg::OUT_W-1:0]      o_dir_x,
    input  wire logic signed [rpd_pkg::OUT_W-1:0]      o_dir_y,
    input  wire logic signed [rpd_pkg::OUT_W-1:0]      o_dir_z,
    input  wire logic                                  o_degenerate
);

    `RPD_ASSERT(a_out_hold, o_valid && i_stall |=> o_valid && $stable(o_dir_x) && $stable(o_dir_y) && $stable(o_dir_z) && $stable(o_degenerate), "stalled result changed")
    `RPD_ASSERT(a_stall_src, o_stall == (o_valid && i_stall), "input stall not tied to output stall")
    `RPD_ASSERT(a_degen_zero, o_valid && o_degenerate |-> o_dir_x == 0 && o_dir_y == 0 && o_dir_z == 0, "degenerate result not zero")
    `RPD_ASSERT(a_unit_nonzero, o_valid && !o_degenerate |-> o_dir_x != 0 || o_dir_y != 0 || o_dir_z != 0, "unit direction came out zero")

endmodule

bind pinhole_primary_ray_direction_top rpd_checker u_rpd_checker (.*);
`default_nettype wire
